[rtl/esp_pkg.sv]
package esp_pkg;

    // Field widths
    localparam int DIR_W   = 16;
    localparam int RAD_W   = 16;
    localparam int OUT_W   = 18;
    localparam int CFG_W   = 16;

    // Datapath widths
    localparam int MAG_W   = 16;            // |dir| up to 2^15
    localparam int MSQ_W   = 2 * MAG_W;     // dir^2
    localparam int RSQ_W   = 2 * RAD_W;     // radius^2
    localparam int SUM_W   = 64;            // sum of r^2 * d^2
    localparam int DSUM_W  = 32;            // sum of d^2
    localparam int ENUM_W  = RSQ_W + MAG_W; // r^2 * |d|
    localparam int RNUM_W  = RAD_W + MAG_W; // c * |d|
    localparam int ROOT_W  = SUM_W / 2;
    localparam int HALF_W  = 5;             // half shift, up to 31
    localparam int NUM_W   = 50;            // shifted numerator plus rounding half
    localparam int QUO_W   = 19;            // quotient bits
    localparam int ACC_W   = QUO_W + 2;

    // Pipeline depths of the arithmetic units
    localparam int NORM_STEPS = 5;          // shifts of 32, 16, 8, 4, 2 bits

    // Output saturation limits
    localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sh1FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 18'sh20000;

    // Register indexes
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_RADIUS_X     = 3'd0;
    localparam cfg_idx_t REG_RADIUS_Y     = 3'd1;
    localparam cfg_idx_t REG_RADIUS_Z     = 3'd2;
    localparam cfg_idx_t REG_ROUNDING     = 3'd3;
    localparam cfg_idx_t REG_INCLUDE      = 3'd4;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd256;

endpackage

[rtl/esp_if.sv]
interface esp_dir_if;
    logic                              valid;
    logic                              ready;
    logic signed [esp_pkg::DIR_W-1:0]  dir_x;
    logic signed [esp_pkg::DIR_W-1:0]  dir_y;
    logic signed [esp_pkg::DIR_W-1:0]  dir_z;

    modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
    modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface esp_point_if;
    logic                              valid;
    logic                              ready;
    logic signed [esp_pkg::OUT_W-1:0]  point_x;
    logic signed [esp_pkg::OUT_W-1:0]  point_y;
    logic signed [esp_pkg::OUT_W-1:0]  point_z;

    modport source (output valid, output point_x, output point_y, output point_z, input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

[rtl/ellipsoid_support_point.sv]
// Ellipsoid support point: for each direction beat on dir_in the block returns
// the point of the axis-aligned ellipsoid (radius_x/y/z, Q8.8) furthest along it
// on point_out (signed Q10.8, saturated to 18 bits), plus rounding_radius along
// the unit direction when include_rounding is set. A zero direction gives the
// origin. One beat enters every clock cycle unless point_out is held off. A beat
// passes 4 sign/multiply/sum stages, a 5-stage normalizer, the 32-stage square
// root (one root bit per stage) and the 19-stage dividers (one quotient bit per
// stage). When point_out is held off, the whole pipeline holds and dir_in.ready
// drops. Write registers through cfg_we/cfg_index/cfg_data only while no beat is
// in flight; squared radii are registered, indexes past 4 are dropped.
module ellipsoid_support_point (
    input  logic                          clk,
    input  logic                          rst_n,
    esp_dir_if.sink                       dir_in,
    esp_point_if.source                   point_out,
    input  logic                          cfg_we,
    input  logic [esp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [esp_pkg::CFG_W-1:0]     cfg_data
);

    // Pipeline depths
    localparam int NUM_LAT = esp_pkg::NORM_STEPS + esp_pkg::ROOT_W;
    localparam int K_LAT   = esp_pkg::ROOT_W;
    localparam int SB_LAT  = NUM_LAT + 1 + esp_pkg::QUO_W;
    localparam int LAT     = 4 + SB_LAT + 1;

    // Flags that ride along to the output stage
    typedef struct packed {
        logic [2:0] neg;
        logic       s_zero;
        logic       d_zero;
    } sb_t;

    // Unshifted numerators that wait for the roots
    typedef struct packed {
        logic [2:0][esp_pkg::ENUM_W-1:0] e;
        logic [2:0][esp_pkg::RNUM_W-1:0] r;
    } nums_t;

    typedef struct packed {
        logic [esp_pkg::HALF_W-1:0] k;
        logic [esp_pkg::HALF_W-1:0] m;
    } shifts_t;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [esp_pkg::RAD_W-1:0] radius_reg [3];
    logic [esp_pkg::RAD_W-1:0] rounding_reg;
    logic                      include_reg;
    logic [esp_pkg::RSQ_W-1:0] rsq_reg    [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg[0] <= esp_pkg::RADIUS_RESET;
            radius_reg[1] <= esp_pkg::RADIUS_RESET;
            radius_reg[2] <= esp_pkg::RADIUS_RESET;
            rounding_reg  <= '0;
            include_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                esp_pkg::REG_RADIUS_X: radius_reg[0] <= cfg_data;
                esp_pkg::REG_RADIUS_Y: radius_reg[1] <= cfg_data;
                esp_pkg::REG_RADIUS_Z: radius_reg[2] <= cfg_data;
                esp_pkg::REG_ROUNDING: rounding_reg  <= cfg_data;
                esp_pkg::REG_INCLUDE:  include_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Squared continuously; the user, not the block, keeps radii static in flight.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            rsq_reg[i] <= esp_pkg::RSQ_W'(radius_reg[i]) * esp_pkg::RSQ_W'(radius_reg[i]);
        end
    end

    // ------------------------------------------------------------------
    // Flow control: one enable for every stage, valid bits in a shift line
    // ------------------------------------------------------------------
    logic [LAT-1:0] vld_reg;
    logic           adv;

    assign adv          = !vld_reg[LAT-1] || point_out.ready;
    assign dir_in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], dir_in.valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: magnitude and sign of each component
    // ------------------------------------------------------------------
    logic signed [esp_pkg::DIR_W-1:0] dir_w [3];
    logic [esp_pkg::MAG_W-1:0]        mag0_reg [3];
    logic [2:0]                       neg0_reg;

    assign dir_w[0] = dir_in.dir_x;
    assign dir_w[1] = dir_in.dir_y;
    assign dir_w[2] = dir_in.dir_z;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                // the most negative input wraps to 0x8000, which reads as +32768
                mag0_reg[i] <= dir_w[i][esp_pkg::DIR_W-1] ? esp_pkg::MAG_W'(-dir_w[i])
                                                          : esp_pkg::MAG_W'(dir_w[i]);
                neg0_reg[i] <= dir_w[i][esp_pkg::DIR_W-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: component squares
    // ------------------------------------------------------------------
    logic [esp_pkg::MSQ_W-1:0] msq1_reg [3];
    logic [esp_pkg::MAG_W-1:0] mag1_reg [3];
    logic [2:0]                neg1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                msq1_reg[i] <= esp_pkg::MSQ_W'(mag0_reg[i]) * esp_pkg::MSQ_W'(mag0_reg[i]);
                mag1_reg[i] <= mag0_reg[i];
            end
            neg1_reg <= neg0_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: weighted squares and numerators
    // ------------------------------------------------------------------
    logic [esp_pkg::SUM_W-1:0]  term_w   [3];
    logic [esp_pkg::ENUM_W-1:0] enum_w   [3];
    logic [esp_pkg::RNUM_W-1:0] rnum_w   [3];
    logic [esp_pkg::SUM_W-1:0]  term2_reg [3];
    logic [esp_pkg::MSQ_W-1:0]  msq2_reg  [3];
    logic [esp_pkg::ENUM_W-1:0] enum2_reg [3];
    logic [esp_pkg::RNUM_W-1:0] rnum2_reg [3];
    logic [2:0]                 neg2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            term_w[i] = esp_pkg::SUM_W'(rsq_reg[i]) * esp_pkg::SUM_W'(msq1_reg[i]);
            enum_w[i] = esp_pkg::ENUM_W'(rsq_reg[i]) * esp_pkg::ENUM_W'(mag1_reg[i]);
            rnum_w[i] = esp_pkg::RNUM_W'(rounding_reg) * esp_pkg::RNUM_W'(mag1_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                term2_reg[i] <= term_w[i];
                msq2_reg[i]  <= msq1_reg[i];
                enum2_reg[i] <= enum_w[i];
                rnum2_reg[i] <= rnum_w[i];
            end
            neg2_reg <= neg1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: the two sums
    // ------------------------------------------------------------------
    logic [esp_pkg::SUM_W-1:0]  s_sum3_reg;
    logic [esp_pkg::DSUM_W-1:0] d_sum3_reg;
    nums_t                      nums3_reg;
    logic [2:0]                 neg3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_sum3_reg <= term2_reg[0] + term2_reg[1] + term2_reg[2];
            d_sum3_reg <= esp_pkg::DSUM_W'(msq2_reg[0]) + esp_pkg::DSUM_W'(msq2_reg[1])
                        + esp_pkg::DSUM_W'(msq2_reg[2]);
            for (int i = 0; i < 3; i++)
            begin
                nums3_reg.e[i] <= enum2_reg[i];
                nums3_reg.r[i] <= rnum2_reg[i];
            end
            neg3_reg <= neg2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Normalize, then take both square roots
    // ------------------------------------------------------------------
    logic [esp_pkg::SUM_W-1:0]  s_norm;
    logic [esp_pkg::SUM_W-1:0]  d_norm;
    logic [esp_pkg::HALF_W-1:0] k_half;
    logic [esp_pkg::HALF_W-1:0] m_half;
    logic [esp_pkg::ROOT_W-1:0] s_root;
    logic [esp_pkg::ROOT_W-1:0] d_root;

    esp_norm u_norm_s (
        .clk   (clk),
        .en    (adv),
        .value (s_sum3_reg),
        .norm  (s_norm),
        .half  (k_half)
    );

    esp_norm u_norm_d (
        .clk   (clk),
        .en    (adv),
        .value (esp_pkg::SUM_W'(d_sum3_reg)),
        .norm  (d_norm),
        .half  (m_half)
    );

    esp_sqrt u_sqrt_s (
        .clk  (clk),
        .en   (adv),
        .rad  (s_norm),
        .root (s_root)
    );

    esp_sqrt u_sqrt_d (
        .clk  (clk),
        .en   (adv),
        .rad  (d_norm),
        .root (d_root)
    );

    // ------------------------------------------------------------------
    // Delay lines that keep the sideband aligned with the roots
    // ------------------------------------------------------------------
    sb_t     sb_line  [SB_LAT];
    nums_t   num_line [NUM_LAT];
    shifts_t k_line   [K_LAT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_line[0].neg    <= neg3_reg;
            sb_line[0].s_zero <= (s_sum3_reg == '0);
            sb_line[0].d_zero <= (d_sum3_reg == '0);
            for (int j = 1; j < SB_LAT; j++)
            begin
                sb_line[j] <= sb_line[j-1];
            end

            num_line[0] <= nums3_reg;
            for (int j = 1; j < NUM_LAT; j++)
            begin
                num_line[j] <= num_line[j-1];
            end

            k_line[0].k <= k_half;
            k_line[0].m <= m_half;
            for (int j = 1; j < K_LAT; j++)
            begin
                k_line[j] <= k_line[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider operands: scale numerator, add half the divisor to round
    // ------------------------------------------------------------------
    logic [esp_pkg::NUM_W-1:0]  e_shift_w [3];
    logic [esp_pkg::NUM_W-1:0]  r_shift_w [3];
    logic [esp_pkg::NUM_W-1:0]  e_num_reg [3];
    logic [esp_pkg::NUM_W-1:0]  r_num_reg [3];
    logic [esp_pkg::ROOT_W-1:0] s_den_reg;
    logic [esp_pkg::ROOT_W-1:0] d_den_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e_shift_w[i] = esp_pkg::NUM_W'(num_line[NUM_LAT-1].e[i]) << k_line[K_LAT-1].k;
            r_shift_w[i] = esp_pkg::NUM_W'(num_line[NUM_LAT-1].r[i]) << k_line[K_LAT-1].m;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e_num_reg[i] <= e_shift_w[i] + esp_pkg::NUM_W'(s_root >> 1);
                r_num_reg[i] <= r_shift_w[i] + esp_pkg::NUM_W'(d_root >> 1);
            end
            s_den_reg <= s_root;
            d_den_reg <= d_root;
        end
    end

    // ------------------------------------------------------------------
    // Six dividers: ellipsoid and rounding part per axis
    // ------------------------------------------------------------------
    logic [esp_pkg::QUO_W-1:0] e_quo [3];
    logic [esp_pkg::QUO_W-1:0] r_quo [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        esp_div u_div_e (
            .clk (clk),
            .en  (adv),
            .num (e_num_reg[i]),
            .den (s_den_reg),
            .quo (e_quo[i])
        );

        esp_div u_div_r (
            .clk (clk),
            .en  (adv),
            .num (r_num_reg[i]),
            .den (d_den_reg),
            .quo (r_quo[i])
        );
    end

    // ------------------------------------------------------------------
    // Output stage: apply signs, add the parts, saturate
    // ------------------------------------------------------------------
    sb_t                              sb_out;
    logic signed [esp_pkg::ACC_W-1:0] e_val [3];
    logic signed [esp_pkg::ACC_W-1:0] r_val [3];
    logic signed [esp_pkg::ACC_W-1:0] acc   [3];
    logic signed [esp_pkg::OUT_W-1:0] sat   [3];
    logic signed [esp_pkg::OUT_W-1:0] point_reg [3];

    assign sb_out = sb_line[SB_LAT-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e_val[i] = sb_out.neg[i] ? -$signed(esp_pkg::ACC_W'(e_quo[i]))
                                     : $signed(esp_pkg::ACC_W'(e_quo[i]));
            r_val[i] = sb_out.neg[i] ? -$signed(esp_pkg::ACC_W'(r_quo[i]))
                                     : $signed(esp_pkg::ACC_W'(r_quo[i]));
            // drop the ellipsoid part for a zero sum, rounding when off or d is zero
            acc[i] = (sb_out.s_zero ? '0 : e_val[i])
                   + ((include_reg && !sb_out.d_zero) ? r_val[i] : '0);
            if (acc[i] > esp_pkg::ACC_W'(esp_pkg::OUT_MAX))
            begin
                sat[i] = esp_pkg::OUT_MAX;
            end
            else if (acc[i] < esp_pkg::ACC_W'(esp_pkg::OUT_MIN))
            begin
                sat[i] = esp_pkg::OUT_MIN;
            end
            else
            begin
                sat[i] = esp_pkg::OUT_W'(acc[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                point_reg[i] <= sat[i];
            end
        end
    end

    assign point_out.valid   = vld_reg[LAT-1];
    assign point_out.point_x = point_reg[0];
    assign point_out.point_y = point_reg[1];
    assign point_out.point_z = point_reg[2];

endmodule

[rtl/esp_norm.sv]
// Even left shift until the top two bits are not both zero, one step per stage.
module esp_norm (
    input  logic                         clk,
    input  logic                         en,
    input  logic [esp_pkg::SUM_W-1:0]    value,
    output logic [esp_pkg::SUM_W-1:0]    norm,
    output logic [esp_pkg::HALF_W-1:0]   half
);

    localparam int STEPS = esp_pkg::NORM_STEPS;

    logic [esp_pkg::SUM_W-1:0]  val_in   [STEPS];
    logic [esp_pkg::HALF_W-1:0] half_in  [STEPS];
    logic [esp_pkg::SUM_W-1:0]  val_reg  [STEPS];
    logic [esp_pkg::HALF_W-1:0] half_reg [STEPS];

    assign val_in[0]  = value;
    assign half_in[0] = '0;

    for (genvar j = 0; j < STEPS; j++)
    begin : g_step
        localparam int SH = 2 ** (STEPS - j);
        logic top_zero;

        if (j > 0)
        begin : g_link
            assign val_in[j]  = val_reg[j-1];
            assign half_in[j] = half_reg[j-1];
        end

        assign top_zero = (val_in[j][esp_pkg::SUM_W-1 -: SH] == '0);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                val_reg[j]  <= top_zero ? (val_in[j] << SH) : val_in[j];
                half_reg[j] <= top_zero ? half_in[j] + esp_pkg::HALF_W'(SH / 2) : half_in[j];
            end
        end
    end

    assign norm = val_reg[STEPS-1];
    assign half = half_reg[STEPS-1];

endmodule

[rtl/esp_sqrt.sv]
// Floor square root, one root bit per stage.
module esp_sqrt (
    input  logic                         clk,
    input  logic                         en,
    input  logic [esp_pkg::SUM_W-1:0]    rad,
    output logic [esp_pkg::ROOT_W-1:0]   root
);

    localparam int RW    = esp_pkg::ROOT_W;
    localparam int REM_W = RW + 2;

    logic [esp_pkg::SUM_W-1:0] x_in     [RW];
    logic [REM_W-1:0]          rem_in   [RW];
    logic [RW-1:0]             root_in  [RW];
    logic [esp_pkg::SUM_W-1:0] x_reg    [RW-1];
    logic [REM_W-1:0]          rem_reg  [RW-1];
    logic [RW-1:0]             root_reg [RW];

    assign x_in[0]    = rad;
    assign rem_in[0]  = '0;
    assign root_in[0] = '0;

    for (genvar j = 0; j < RW; j++)
    begin : g_bit
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic             ge;

        if (j > 0)
        begin : g_link
            assign x_in[j]    = x_reg[j-1];
            assign rem_in[j]  = rem_reg[j-1];
            assign root_in[j] = root_reg[j-1];
        end

        assign rem_sh = {rem_in[j][REM_W-3:0], x_in[j][esp_pkg::SUM_W-1 -: 2]};
        assign trial  = {root_in[j], 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[j] <= {root_in[j][RW-2:0], ge};
            end
        end

        if (j < RW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= ge ? rem_sh - trial : rem_sh;
                    x_reg[j]   <= x_in[j] << 2;
                end
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

[rtl/esp_div.sv]
// Restoring divider, one quotient bit per stage; num >> QUO_W must be below den.
module esp_div (
    input  logic                         clk,
    input  logic                         en,
    input  logic [esp_pkg::NUM_W-1:0]    num,
    input  logic [esp_pkg::ROOT_W-1:0]   den,
    output logic [esp_pkg::QUO_W-1:0]    quo
);

    localparam int QW = esp_pkg::QUO_W;
    localparam int DW = esp_pkg::ROOT_W;

    logic [DW-1:0] rem_in  [QW];
    logic [QW-1:0] low_in  [QW];
    logic [QW-1:0] quo_in  [QW];
    logic [DW-1:0] den_in  [QW];
    logic [DW-1:0] rem_reg [QW-1];
    logic [QW-1:0] low_reg [QW-1];
    logic [DW-1:0] den_reg [QW-1];
    logic [QW-1:0] quo_reg [QW];

    assign rem_in[0] = DW'(num[esp_pkg::NUM_W-1:QW]);
    assign low_in[0] = num[QW-1:0];
    assign quo_in[0] = '0;
    assign den_in[0] = den;

    for (genvar j = 0; j < QW; j++)
    begin : g_bit
        logic [DW:0] sh;
        logic        ge;

        if (j > 0)
        begin : g_link
            assign rem_in[j] = rem_reg[j-1];
            assign low_in[j] = low_reg[j-1];
            assign quo_in[j] = quo_reg[j-1];
            assign den_in[j] = den_reg[j-1];
        end

        assign sh = {rem_in[j], low_in[j][QW-1]};
        assign ge = (sh >= {1'b0, den_in[j]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[j] <= {quo_in[j][QW-2:0], ge};
            end
        end

        if (j < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= ge ? DW'(sh - {1'b0, den_in[j]}) : DW'(sh);
                    low_reg[j] <= low_in[j] << 1;
                    den_reg[j] <= den_in[j];
                end
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

[rtl/esp_chk.sv]
module esp_chk (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic signed [esp_pkg::OUT_W-1:0] point_x,
    input logic signed [esp_pkg::OUT_W-1:0] point_y,
    input logic signed [esp_pkg::OUT_W-1:0] point_z
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(point_x)
                                    && $stable(point_y) && $stable(point_z))
        else $error("stalled result beat changed");

    // input is held off only by a stalled result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result beat during reset");

    // an empty pipe after reset shows no result when reset is first seen released
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result beat right after reset");

endmodule

bind ellipsoid_support_point esp_chk u_esp_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (dir_in.ready),
    .out_valid (point_out.valid),
    .out_ready (point_out.ready),
    .point_x   (point_out.point_x),
    .point_y   (point_out.point_y),
    .point_z   (point_out.point_z)
);

[verif/tb_top.sv]
module tb_top;

    typedef struct packed {
        logic signed [esp_pkg::DIR_W-1:0] x;
        logic signed [esp_pkg::DIR_W-1:0] y;
        logic signed [esp_pkg::DIR_W-1:0] z;
    } dir_t;

    typedef struct packed {
        logic signed [esp_pkg::OUT_W-1:0] x;
        logic signed [esp_pkg::OUT_W-1:0] y;
        logic signed [esp_pkg::OUT_W-1:0] z;
    } point_t;

    // Pipeline depth of the block (LAT in its code); used for the settle pauses.
    localparam int LATENCY   = 62;
    localparam int MAX_GAP   = 5;
    localparam int CYCLE_CAP = 400000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    esp_pkg::cfg_idx_t cfg_index;
    logic [esp_pkg::CFG_W-1:0] cfg_data;

    esp_dir_if   dir_bus ();
    esp_point_if point_bus ();

    ellipsoid_support_point i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .dir_in    (dir_bus),
        .point_out (point_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the configuration registers.
    logic [esp_pkg::RAD_W-1:0] sh_rad [3];
    logic [esp_pkg::RAD_W-1:0] sh_round;
    logic                      sh_incl;

    dir_t   pending_dirs [$];
    point_t expected_points [$];
    int     errors;
    int     cycles;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Square root of a 64-bit value, floor.
    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Normalize to at least 2^62 by even shifts, root it, report half shift.
    function automatic logic [63:0] norm_root(logic [63:0] v, output int half);
        half = 0;
        while (v < (64'd1 << 62))
        begin
            v = v << 2;
            half++;
        end
        return floor_root(v);
    endfunction

    function automatic longint round_div(logic [63:0] num, int sh, logic [63:0] den,
                                         bit neg);
        logic [63:0] q;
        q = ((num << sh) + (den >> 1)) / den;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic point_t support_point(dir_t d);
        longint      acc [3];
        logic [63:0] mag [3];
        logic [63:0] rsq [3];
        bit          neg [3];
        logic [63:0] s_sum;
        logic [63:0] d_sum;
        logic [63:0] root;
        int          half;
        logic signed [esp_pkg::DIR_W-1:0] comp [3];
        point_t      p;
        longint      v;
        comp[0] = d.x;
        comp[1] = d.y;
        comp[2] = d.z;
        s_sum = 0;
        d_sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = comp[i] < 0;
            mag[i] = neg[i] ? 64'(-longint'(comp[i])) : 64'(longint'(comp[i]));
            rsq[i] = 64'(sh_rad[i]) * 64'(sh_rad[i]);
            s_sum += rsq[i] * (mag[i] * mag[i]);
            d_sum += mag[i] * mag[i];
            acc[i] = 0;
        end
        if (s_sum != 0)
        begin
            root = norm_root(s_sum, half);
            for (int i = 0; i < 3; i++)
                acc[i] += round_div(rsq[i] * mag[i], half, root, neg[i]);
        end
        if (sh_incl && d_sum != 0)
        begin
            root = norm_root(d_sum, half);
            for (int i = 0; i < 3; i++)
                acc[i] += round_div(64'(sh_round) * mag[i], half, root, neg[i]);
        end
        for (int i = 0; i < 3; i++)
        begin
            v = acc[i];
            if (v > 131071)
                v = 131071;
            if (v < -131072)
                v = -131072;
            acc[i] = v;
        end
        p.x = acc[0][esp_pkg::OUT_W-1:0];
        p.y = acc[1][esp_pkg::OUT_W-1:0];
        p.z = acc[2][esp_pkg::OUT_W-1:0];
        return p;
    endfunction

    // Driver: pop a direction, hold it until accepted, then idle a random gap.
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_bus.valid <= 1'b0;
            dir_bus.dir_x <= '0;
            dir_bus.dir_y <= '0;
            dir_bus.dir_z <= '0;
            send_gap      <= 0;
        end
        else
        begin
            if (dir_bus.valid && dir_bus.ready)
                expected_points.push_back(support_point({dir_bus.dir_x, dir_bus.dir_y,
                                                         dir_bus.dir_z}));
            if (!dir_bus.valid || dir_bus.ready)
            begin
                if (send_gap > 0)
                begin
                    dir_bus.valid <= 1'b0;
                    send_gap      <= send_gap - 1;
                end
                else if (pending_dirs.size() > 0)
                begin
                    dir_t nd;
                    nd = pending_dirs.pop_front();
                    dir_bus.valid <= 1'b1;
                    dir_bus.dir_x <= nd.x;
                    dir_bus.dir_y <= nd.y;
                    dir_bus.dir_z <= nd.z;
                    // Mostly back to back bursts, sometimes a gap.
                    send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
                end
                else
                    dir_bus.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each point beat with the oldest prediction.
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_bus.ready <= 1'b0;
            stall_left      <= 0;
        end
        else
        begin
            if (point_bus.valid && point_bus.ready)
            begin
                if (expected_points.size() == 0)
                begin
                    $display("%0t: unexpected point %0d %0d %0d", $time,
                             point_bus.point_x, point_bus.point_y, point_bus.point_z);
                    errors++;
                end
                else
                begin
                    point_t ep;
                    ep = expected_points.pop_front();
                    if (ep.x !== point_bus.point_x)
                    begin
                        $display("%0t: point_x expected %0d actual %0d", $time, ep.x,
                                 point_bus.point_x);
                        errors++;
                    end
                    if (ep.y !== point_bus.point_y)
                    begin
                        $display("%0t: point_y expected %0d actual %0d", $time, ep.y,
                                 point_bus.point_y);
                        errors++;
                    end
                    if (ep.z !== point_bus.point_z)
                    begin
                        $display("%0t: point_z expected %0d actual %0d", $time, ep.z,
                                 point_bus.point_z);
                        errors++;
                    end
                end
            end
            // Stall draws: a run of low ready, then high until the next draw.
            if (stall_left > 0)
            begin
                point_bus.ready <= 1'b0;
                stall_left      <= stall_left - 1;
            end
            else
            begin
                point_bus.ready <= 1'b1;
                if (point_bus.valid && point_bus.ready && $urandom_range(0, 3) == 0)
                    stall_left <= $urandom_range(0, MAX_GAP);
            end
        end
    end

    // Watchdog: end the run on a hang.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic cfg_write(esp_pkg::cfg_idx_t idx, logic [esp_pkg::CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            esp_pkg::REG_RADIUS_X: sh_rad[0] = val;
            esp_pkg::REG_RADIUS_Y: sh_rad[1] = val;
            esp_pkg::REG_RADIUS_Z: sh_rad[2] = val;
            esp_pkg::REG_ROUNDING: sh_round  = val;
            esp_pkg::REG_INCLUDE:  sh_incl   = val[0];
            default: ;
        endcase
    endtask

    // Hold until every beat has come out, then let the pipe drain.
    task automatic drain();
        while (pending_dirs.size() > 0 || dir_bus.valid || expected_points.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic queue_dir(int x, int y, int z);
        dir_t d;
        d.x = esp_pkg::DIR_W'(x);
        d.y = esp_pkg::DIR_W'(y);
        d.z = esp_pkg::DIR_W'(z);
        pending_dirs.push_back(d);
    endtask

    function automatic int rand_comp();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 3) - 1;
            1: return $urandom_range(0, 1) ? 32767 : -32768;
            2: return int'($urandom_range(0, 255)) - 128;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic logic [esp_pkg::RAD_W-1:0] rand_radius();
        case ($urandom_range(0, 5))
            0: return 16'hFFFF;
            1: return esp_pkg::RAD_W'($urandom_range(0, 1));
            2: return esp_pkg::RAD_W'($urandom_range(1, 1024));
            default: return esp_pkg::RAD_W'($urandom_range(0, 65535));
        endcase
    endfunction

    initial
    begin
        errors    = 0;
        cycles    = 0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = esp_pkg::REG_RADIUS_X;
        cfg_data  = '0;
        sh_rad[0] = esp_pkg::RADIUS_RESET;
        sh_rad[1] = esp_pkg::RADIUS_RESET;
        sh_rad[2] = esp_pkg::RADIUS_RESET;
        sh_round  = '0;
        sh_incl   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings: zero direction, axes, extremes.
        queue_dir(0, 0, 0);
        queue_dir(1, 0, 0);
        queue_dir(0, -1, 0);
        queue_dir(0, 0, 32767);
        queue_dir(-32768, -32768, -32768);
        queue_dir(32767, 32767, 32767);
        queue_dir(-32768, 32767, 1);
        queue_dir(3, -4, 12);
        drain();

        // Max radii plus rounding: saturation, and a zero direction in include mode.
        cfg_write(esp_pkg::REG_RADIUS_X, 16'hFFFF);
        cfg_write(esp_pkg::REG_RADIUS_Y, 16'hFFFF);
        cfg_write(esp_pkg::REG_RADIUS_Z, 16'hFFFF);
        cfg_write(esp_pkg::REG_ROUNDING, 16'hFFFF);
        cfg_write(esp_pkg::REG_INCLUDE, 16'd1);
        cfg_write(esp_pkg::cfg_idx_t'(5), 16'h1234); // out-of-range index, dropped
        queue_dir(0, 0, 0);
        queue_dir(-32768, 0, 0);
        queue_dir(1, 1, 1);
        queue_dir(-1, 32767, -7);
        drain();

        // Zero x and y radii, z radius of 1: rounding part only where z is zero.
        cfg_write(esp_pkg::REG_RADIUS_X, 16'd0);
        cfg_write(esp_pkg::REG_RADIUS_Y, 16'd0);
        cfg_write(esp_pkg::REG_RADIUS_Z, 16'd1);
        cfg_write(esp_pkg::REG_ROUNDING, 16'd300);
        queue_dir(5, -9, 0);
        queue_dir(0, 0, -3);
        queue_dir(-32768, 32767, 0);
        queue_dir(0, 0, 0);
        drain();

        // Random phases with fresh settings between them.
        for (int ph = 0; ph < 37; ph++)
        begin
            cfg_write(esp_pkg::REG_RADIUS_X, rand_radius());
            cfg_write(esp_pkg::REG_RADIUS_Y, rand_radius());
            cfg_write(esp_pkg::REG_RADIUS_Z, rand_radius());
            cfg_write(esp_pkg::REG_ROUNDING, rand_radius());
            cfg_write(esp_pkg::REG_INCLUDE, esp_pkg::CFG_W'($urandom_range(0, 1)));
            for (int n = 0; n < 50; n++)
                queue_dir(rand_comp(), rand_comp(), rand_comp());
            drain();
        end

        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/esp_pkg.sv
rtl/esp_if.sv
rtl/esp_norm.sv
rtl/esp_sqrt.sv
rtl/esp_div.sv
rtl/ellipsoid_support_point.sv
rtl/esp_chk.sv
verif/tb_top.sv
